/* design/sipq_pkg.sv */
package sipq_pkg;

	localparam int DATA_W    = 32;
	localparam int PRIO_W    = 16;
	localparam int HPRIO_W   = 17;
	localparam int CAP_W     = 5;
	localparam int STATUS_W  = 2;
	localparam int COUNT_O_W = 5;

	localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_REMOVE = 1'b1;

	localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
	localparam logic [STATUS_W-1:0] ST_BAD_PRIO = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL     = 2'd2;
	localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd3;

	// commands from the controller to the datapath
	typedef struct packed {
		logic capture;
		logic execute;
	} cmd_t;

endpackage

/* design/sipq_ctrl.sv */
module sipq_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_stall,
	output logic           out_valid,
	input  logic           out_stall,
	output sipq_pkg::cmd_t cmd
);
	import sipq_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_EXEC = 2'b10
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;
	logic   slot_free;

	assign slot_free   = !out_valid_q || !out_stall;
	assign in_stall    = (state_q != S_IDLE);
	assign cmd.capture = in_valid && (state_q == S_IDLE);
	assign cmd.execute = (state_q == S_EXEC) && slot_free;
	assign out_valid   = out_valid_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) state_d = S_EXEC;
			end
			S_EXEC: begin
				if (slot_free) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.execute) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
		end
	end

	// a result never overwrites one that is still waiting
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.execute |-> !(out_valid_q && out_stall))
		else $error("result register overwritten while stalled");

	// every captured request moves the controller into the execute state
	a_capture_then_exec: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.capture |=> (state_q == S_EXEC))
		else $error("captured request not held for execution");

	// a stalled result stays until it is taken
	a_hold_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_stall) |=> out_valid_q)
		else $error("stalled result dropped");

endmodule

/* design/sipq_dpath.sv */
module sipq_dpath #(
	parameter int QUEUE_DEPTH = 16
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  sipq_pkg::cmd_t                         cmd,
	input  logic                                   cfg_wr_en,
	input  logic        [sipq_pkg::CAP_W-1:0]      cfg_wr_data,
	input  logic                                   operation,
	input  logic signed [sipq_pkg::DATA_W-1:0]     item_data,
	input  logic        [sipq_pkg::PRIO_W-1:0]     item_priority,
	output logic        [sipq_pkg::STATUS_W-1:0]   status,
	output logic signed [sipq_pkg::DATA_W-1:0]     head_data,
	output logic signed [sipq_pkg::HPRIO_W-1:0]    head_priority,
	output logic        [sipq_pkg::COUNT_O_W-1:0]  entry_count
);
	import sipq_pkg::*;

	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

	logic [CAP_W-1:0]  cap_q;
	logic [CNT_W-1:0]  count_q;
	logic              op_q;
	logic [DATA_W-1:0] data_q;
	logic [PRIO_W-1:0] prio_q;

	logic [DATA_W-1:0] cell_data_q [QUEUE_DEPTH];
	logic [PRIO_W-1:0] cell_prio_q [QUEUE_DEPTH];
	logic [QUEUE_DEPTH-1:0] take;

	logic [CMP_W-1:0] count_ext;
	logic             is_full;
	logic             is_empty;
	logic             insert_ok;
	logic             remove_ok;

	logic [STATUS_W-1:0]  status_q;
	logic [DATA_W-1:0]    head_data_q;
	logic [HPRIO_W-1:0]   head_prio_q;
	logic [COUNT_O_W-1:0] entry_count_q;

	assign count_ext = CMP_W'(count_q);
	assign is_full   = (count_ext >= CMP_W'(cap_q)) || (count_ext >= CMP_W'(QUEUE_DEPTH));
	assign is_empty  = (count_q == '0);
	assign insert_ok = (op_q == OP_INSERT) && (prio_q != '0) && !is_full;
	assign remove_ok = (op_q == OP_REMOVE) && !is_empty;

	// a cell moves down when it lies past the count or holds a larger number
	always_comb begin
		for (int k = 0; k < QUEUE_DEPTH; k++) begin
			take[k] = (CNT_W'(k) >= count_q) || (cell_prio_q[k] > prio_q);
		end
	end

	for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
		always_ff @(posedge clk) begin
			if (cmd.execute && insert_ok && take[g]) begin
				if (g == 0) begin
					cell_data_q[g] <= data_q;
					cell_prio_q[g] <= prio_q;
				end else if (!take[(g == 0) ? 0 : g-1]) begin
					cell_data_q[g] <= data_q;
					cell_prio_q[g] <= prio_q;
				end else begin
					cell_data_q[g] <= cell_data_q[(g == 0) ? 0 : g-1];
					cell_prio_q[g] <= cell_prio_q[(g == 0) ? 0 : g-1];
				end
			end else if (cmd.execute && remove_ok && (g < QUEUE_DEPTH-1)) begin
				cell_data_q[g] <= cell_data_q[(g < QUEUE_DEPTH-1) ? g+1 : g];
				cell_prio_q[g] <= cell_prio_q[(g < QUEUE_DEPTH-1) ? g+1 : g];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q   <= operation;
			data_q <= item_data;
			prio_q <= item_priority;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q   <= CAP_RESET;
			count_q <= '0;
		end else begin
			if (cfg_wr_en) cap_q <= cfg_wr_data;
			if (cmd.execute && insert_ok) count_q <= count_q + CNT_W'(1);
			else if (cmd.execute && remove_ok) count_q <= count_q - CNT_W'(1);
		end
	end

	// result register, loaded with the outcome of the executed request
	always_ff @(posedge clk) begin
		if (cmd.execute) begin
			head_data_q <= '1;
			head_prio_q <= '1;
			status_q    <= ST_OK;
			if (op_q == OP_INSERT) begin
				if (prio_q == '0) status_q <= ST_BAD_PRIO;
				else if (is_full) status_q <= ST_FULL;
				if (insert_ok) entry_count_q <= COUNT_O_W'(count_ext + CMP_W'(1));
				else entry_count_q <= COUNT_O_W'(count_ext);
			end else begin
				if (is_empty) begin
					status_q      <= ST_EMPTY;
					entry_count_q <= COUNT_O_W'(count_ext);
				end else begin
					head_data_q   <= cell_data_q[0];
					head_prio_q   <= {1'b0, cell_prio_q[0]};
					entry_count_q <= COUNT_O_W'(count_ext - CMP_W'(1));
				end
			end
		end
	end

	assign status        = status_q;
	assign head_data     = head_data_q;
	assign head_priority = head_prio_q;
	assign entry_count   = entry_count_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(QUEUE_DEPTH))
		else $error("entry count beyond queue depth");

	a_remove_dec: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.execute && remove_ok) |=> (count_q == $past(count_q) - CNT_W'(1)))
		else $error("remove did not decrement the count");

	a_bad_prio_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.execute && (op_q == OP_INSERT) && (prio_q == '0)) |=> $stable(count_q))
		else $error("rejected insert changed the count");

	a_head_sorted: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q >= CNT_W'(2)) |-> (cell_prio_q[0] <= cell_prio_q[1]))
		else $error("head entry out of order");

endmodule

/* design/sorted_insert_priority_queue_core.sv */
// a request is captured into the operand registers at the accepting edge and executed once
// the result register is free, which then holds its outcome
// the controller captures and executes in turn, so no new request is taken until the last one executes;
// a waiting result does not block the next request, only its execution
// reset: arst_n clears the entry count and sets capacity to 16; entry cells are not cleared
module sorted_insert_priority_queue_core #(
	parameter int QUEUE_DEPTH = 16
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   cfg_wr_en,
	input  logic        [sipq_pkg::CAP_W-1:0]      cfg_wr_data,
	input  logic                                   in_valid,
	output logic                                   in_stall,
	input  logic                                   operation,
	input  logic signed [sipq_pkg::DATA_W-1:0]     item_data,
	input  logic        [sipq_pkg::PRIO_W-1:0]     item_priority,
	output logic                                   out_valid,
	input  logic                                   out_stall,
	output logic        [sipq_pkg::STATUS_W-1:0]   status,
	output logic signed [sipq_pkg::DATA_W-1:0]     head_data,
	output logic signed [sipq_pkg::HPRIO_W-1:0]    head_priority,
	output logic        [sipq_pkg::COUNT_O_W-1:0]  entry_count
);
	import sipq_pkg::*;

	cmd_t cmd;

	sipq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd)
	);

	sipq_dpath #(
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) u_dpath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data),
		.operation     (operation),
		.item_data     (item_data),
		.item_priority (item_priority),
		.status        (status),
		.head_data     (head_data),
		.head_priority (head_priority),
		.entry_count   (entry_count)
	);

endmodule
